// ----- sv/block_edge_deblock_filter_core_assert.svh -----
// Assertion macros for the edge deblocking filter core.
// Used by the RTL in this folder; simulation-only, empty under synthesis.
`ifndef BLOCK_EDGE_DEBLOCK_FILTER_CORE_ASSERT_SVH
`define BLOCK_EDGE_DEBLOCK_FILTER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Property checked at every rising edge while reset is released.
`define BEDF_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Property checked at every rising edge, reset included.
`define BEDF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define BEDF_ASSERT(lbl, clk, rstn, prop, msg)
`define BEDF_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ----- sv/bedf_pkg.sv -----
// Shared types and constants of the edge deblocking filter core.
// Depends on nothing; used by block_edge_deblock_filter_core.
package bedf_pkg;

  // Width of every sample field on the stream ports; each configuration register is CfgW wide.
  localparam int FieldW    = 16;
  localparam int CfgW      = 16;
  localparam int ApbDataW  = 32;
  localparam int ApbAddrW  = 5;
  localparam int InFields  = 6;
  localparam int OutFields = 4;

  // Rounding bias and shift of the edge delta.
  localparam int DeltaBias  = 4;
  localparam int DeltaShift = 3;

  // Register map, index = byte address / 4.
  typedef enum logic [2:0] {
    REG_ALPHA_LIMIT = 3'd0,
    REG_BETA_LIMIT  = 3'd1,
    REG_CLIP_BASE   = 3'd2,
    REG_CLIP_STEP   = 3'd3,
    REG_SAMPLE_PEAK = 3'd4
  } cfg_reg_e;

  localparam logic [CfgW-1:0] AlphaRst = 16'd0;
  localparam logic [CfgW-1:0] BetaRst  = 16'd0;
  localparam logic [CfgW-1:0] ClipBaseRst = 16'd0;
  localparam logic [CfgW-1:0] ClipStepRst = 16'd1;
  localparam logic [CfgW-1:0] PeakRst  = 16'd255;

endpackage

// ----- sv/block_edge_deblock_filter_core.sv -----
// Top level of the normal-strength edge deblocking filter core.
// Depends on bedf_pkg and block_edge_deblock_filter_core_assert.svh.

// The core filters one line of six samples p2 p1 p0 | q0 q1 q2 across a block
// edge per item, in the manner of the normal-strength H.264 deblocking filter.
// It accepts one item every clock cycle while the output is not stalled, and
// each item passes through the input register and then the result register,
// with all filter arithmetic in the logic between them. The result register
// lets a new item enter while a finished result still waits on the output;
// backpressure on the output stalls both stages together. The user must
// write thresholds, clip values and the sample peak over the APB port only
// while the core is idle; the core itself does not enforce this. Samples
// are taken modulo 2^SAMPLE_BITS; results are zero-extended to 16 bits per field.
module block_edge_deblock_filter_core #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Input stream: p2, p1, p0, q0, q1, q2, 16 bits each, from bit 0 up.
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [bedf_pkg::InFields*bedf_pkg::FieldW-1:0]  s_axis_tdata,
  // Output stream: p1_out, p0_out, q0_out, q1_out, 16 bits each, from bit 0 up.
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [bedf_pkg::OutFields*bedf_pkg::FieldW-1:0] m_axis_tdata,
  // Output flag: edge_filtered (bit 0).
  output logic                           m_axis_tuser,
  // APB configuration port.
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bedf_pkg::ApbAddrW-1:0]  paddr,
  input  logic [bedf_pkg::ApbDataW-1:0]  pwdata,
  output logic [bedf_pkg::ApbDataW-1:0]  prdata,
  output logic                           pready
);

  `include "block_edge_deblock_filter_core_assert.svh"

  localparam int S      = SAMPLE_BITS;
  localparam int FW     = bedf_pkg::FieldW;
  localparam int CW     = bedf_pkg::CfgW;
  // The clip limit c0 + 2*c1 needs two bits beyond a register.
  localparam int ClipW  = CW + 2;
  // Signed width that holds 4*(q0-p0) + p1 - q1 + 4 and the clip limit.
  localparam int AW     = (S + 4 > ClipW + 1) ? S + 4 : ClipW + 1;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [CW-1:0] alpha_q, beta_q, c0_q, c1_q, peak_q;
  logic          cfg_wr;
  bedf_pkg::cfg_reg_e cfg_sel;

  assign pready  = 1'b1;
  assign cfg_sel = bedf_pkg::cfg_reg_e'(paddr[bedf_pkg::ApbAddrW-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= bedf_pkg::AlphaRst;
      beta_q  <= bedf_pkg::BetaRst;
      c0_q    <= bedf_pkg::ClipBaseRst;
      c1_q    <= bedf_pkg::ClipStepRst;
      peak_q  <= bedf_pkg::PeakRst;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        bedf_pkg::REG_ALPHA_LIMIT: alpha_q <= pwdata[CW-1:0];
        bedf_pkg::REG_BETA_LIMIT:  beta_q  <= pwdata[CW-1:0];
        bedf_pkg::REG_CLIP_BASE:   c0_q    <= pwdata[CW-1:0];
        bedf_pkg::REG_CLIP_STEP:   c1_q    <= pwdata[CW-1:0];
        bedf_pkg::REG_SAMPLE_PEAK: peak_q  <= pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      bedf_pkg::REG_ALPHA_LIMIT: prdata = bedf_pkg::ApbDataW'(alpha_q);
      bedf_pkg::REG_BETA_LIMIT:  prdata = bedf_pkg::ApbDataW'(beta_q);
      bedf_pkg::REG_CLIP_BASE:   prdata = bedf_pkg::ApbDataW'(c0_q);
      bedf_pkg::REG_CLIP_STEP:   prdata = bedf_pkg::ApbDataW'(c1_q);
      bedf_pkg::REG_SAMPLE_PEAK: prdata = bedf_pkg::ApbDataW'(peak_q);
      default:                   prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipeline control. Both stages move together whenever the result register
  // is empty or its item is being taken.
  // ---------------------------------------------------------------------------
  logic in_valid_q, out_valid_q;
  logic advance, in_take;

  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  // Input register: samples reduced to the configured depth.
  logic [S-1:0] p2_q, p1_q, p0_q, q0_q, q1_q, q2_q;

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      p2_q <= s_axis_tdata[0*FW +: S];
      p1_q <= s_axis_tdata[1*FW +: S];
      p0_q <= s_axis_tdata[2*FW +: S];
      q0_q <= s_axis_tdata[3*FW +: S];
      q1_q <= s_axis_tdata[4*FW +: S];
      q2_q <= s_axis_tdata[5*FW +: S];
    end
  end

  // ---------------------------------------------------------------------------
  // Filter arithmetic between the input and result registers.
  // ---------------------------------------------------------------------------
  logic [S-1:0]        d_p0q0, d_p1p0, d_q0q1, d_p2p0, d_q2q0;
  logic                pass, smooth_p, smooth_q;
  logic [ClipW-1:0]    clip_lim;
  logic signed [AW-1:0] p2s, p1s, p0s, q0s, q1s, q2s;
  logic signed [AW-1:0] c_s, c0_s, peak_s;
  logic signed [AW-1:0] delta_raw, delta, p0_sum, q0_sum, p0_clamp, q0_clamp;
  logic [S:0]          avg_sum;
  logic signed [AW-1:0] avg_s, dp_raw, dq_raw, dp, dq, p1_adj, q1_adj;
  logic [S-1:0]        p1_new, p0_new, q0_new, q1_new;

  always_comb begin
    d_p0q0 = (p0_q > q0_q) ? p0_q - q0_q : q0_q - p0_q;
    d_p1p0 = (p1_q > p0_q) ? p1_q - p0_q : p0_q - p1_q;
    d_q0q1 = (q0_q > q1_q) ? q0_q - q1_q : q1_q - q0_q;
    d_p2p0 = (p2_q > p0_q) ? p2_q - p0_q : p0_q - p2_q;
    d_q2q0 = (q2_q > q0_q) ? q2_q - q0_q : q0_q - q2_q;

    pass     = (CW'(d_p0q0) < alpha_q) && (CW'(d_p1p0) < beta_q) &&
               (CW'(d_q0q1) < beta_q);
    smooth_p = CW'(d_p2p0) < beta_q;
    smooth_q = CW'(d_q2q0) < beta_q;

    // Clip limit grows by c1 for each smooth side.
    clip_lim = ClipW'(c0_q) + (smooth_p ? ClipW'(c1_q) : '0) +
               (smooth_q ? ClipW'(c1_q) : '0);

    p2s    = $signed(AW'(p2_q));
    p1s    = $signed(AW'(p1_q));
    p0s    = $signed(AW'(p0_q));
    q0s    = $signed(AW'(q0_q));
    q1s    = $signed(AW'(q1_q));
    q2s    = $signed(AW'(q2_q));
    c_s    = $signed(AW'(clip_lim));
    c0_s   = $signed(AW'(c0_q));
    peak_s = $signed(AW'(peak_q));

    // Edge delta with rounding; arithmetic shift gives floor division.
    delta_raw = (((q0s - p0s) <<< 2) + p1s - q1s + $signed(AW'(bedf_pkg::DeltaBias)))
                >>> bedf_pkg::DeltaShift;
    if (delta_raw > c_s) begin
      delta = c_s;
    end else if (delta_raw < -c_s) begin
      delta = -c_s;
    end else begin
      delta = delta_raw;
    end

    p0_sum = p0s + delta;
    q0_sum = q0s - delta;
    if (p0_sum < 0) begin
      p0_clamp = '0;
    end else if (p0_sum > peak_s) begin
      p0_clamp = peak_s;
    end else begin
      p0_clamp = p0_sum;
    end
    if (q0_sum < 0) begin
      q0_clamp = '0;
    end else if (q0_sum > peak_s) begin
      q0_clamp = peak_s;
    end else begin
      q0_clamp = q0_sum;
    end

    // Inner samples move toward the mean of the outer sample and the edge average.
    avg_sum = (S+1)'(p0_q) + (S+1)'(q0_q) + (S+1)'(1);
    avg_s   = $signed(AW'(avg_sum[S:1]));
    dp_raw  = (p2s + avg_s - (p1s <<< 1)) >>> 1;
    dq_raw  = (q2s + avg_s - (q1s <<< 1)) >>> 1;
    if (dp_raw > c0_s) begin
      dp = c0_s;
    end else if (dp_raw < -c0_s) begin
      dp = -c0_s;
    end else begin
      dp = dp_raw;
    end
    if (dq_raw > c0_s) begin
      dq = c0_s;
    end else if (dq_raw < -c0_s) begin
      dq = -c0_s;
    end else begin
      dq = dq_raw;
    end
    p1_adj = p1s + dp;
    q1_adj = q1s + dq;

    p1_new = (pass && smooth_p) ? p1_adj[S-1:0] : p1_q;
    q1_new = (pass && smooth_q) ? q1_adj[S-1:0] : q1_q;
    p0_new = pass ? p0_clamp[S-1:0] : p0_q;
    q0_new = pass ? q0_clamp[S-1:0] : q0_q;
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic [S-1:0] p1_out_q, p0_out_q, q0_out_q, q1_out_q;
  logic         edge_q;

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q) begin
      p1_out_q <= p1_new;
      p0_out_q <= p0_new;
      q0_out_q <= q0_new;
      q1_out_q <= q1_new;
      edge_q   <= pass;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {FW'(q1_out_q), FW'(q0_out_q), FW'(p0_out_q), FW'(p1_out_q)};
  assign m_axis_tuser  = edge_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // A finished result leaves the result register only through a handshake.
  `BEDF_ASSERT(a_result_not_dropped, clk_i, rst_ni,
    $fell(out_valid_q) |-> $past(m_axis_tready), "result dropped without handshake")
  // A line that fails the thresholds reaches the output unchanged.
  `BEDF_ASSERT(a_unfiltered_passthru, clk_i, rst_ni,
    (advance && in_valid_q && !pass) |=> (p0_out_q == $past(p0_q)) &&
    (q0_out_q == $past(q0_q)) && !edge_q, "unfiltered line was modified")
  // The clamp keeps the new edge samples within zero and the peak.
  `BEDF_ASSERT(a_clamp_range, clk_i, rst_ni,
    in_valid_q |-> (!pass || ((p0_clamp >= 0) && (p0_clamp <= peak_s) &&
    (q0_clamp >= 0) && (q0_clamp <= peak_s))), "edge sample outside the clamp range")
  // A side that is not smooth keeps its inner sample.
  `BEDF_ASSERT(a_rough_side_kept, clk_i, rst_ni,
    in_valid_q |-> ((smooth_p || (p1_new == p1_q)) && (smooth_q || (q1_new == q1_q))),
    "inner sample changed on a rough side")

endmodule
